[rtl/core/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types, letter codes, register map and key square tables for the
// playfair digraph cipher
// ----------------------------------------------------------------------------
package pfc_pkg;

   // key square geometry
   localparam int GRID_SIDE     = 5;
   localparam int CELL_COUNT    = GRID_SIDE * GRID_SIDE;
   localparam int CODE_W        = 5;
   localparam int IDX_W         = 5;
   localparam int POS_W         = 3;
   localparam int CELLS_PER_REG = 10;

   // letter codes
   localparam logic [CODE_W-1:0] CODE_I   = 5'd8;
   localparam logic [CODE_W-1:0] CODE_J   = 5'd9;
   localparam logic [CODE_W-1:0] CODE_Q   = 5'd16;
   localparam logic [CODE_W-1:0] CODE_X   = 5'd23;
   localparam logic [CODE_W-1:0] CODE_Z   = 5'd25;
   localparam logic [CODE_W-1:0] CODE_MAX = 5'd25;

   // request commands
   localparam logic CMD_LETTER = 1'b0;
   localparam logic CMD_END    = 1'b1;

   // direction register values
   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   // register map, one register every 8 bytes
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 64;
   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_CELLS_LOW  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_CELLS_MID  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_CELLS_HIGH = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_DIRECTION  = 2'd3;

   // row and column of each cell, row-major
   localparam logic [POS_W-1:0] ROW_OF [CELL_COUNT] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4
   };
   localparam logic [POS_W-1:0] COL_OF [CELL_COUNT] = '{
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4
   };

   typedef logic [CELL_COUNT-1:0][CODE_W-1:0] cells_type;

   typedef struct packed {
      logic              cmd;
      logic [CODE_W-1:0] letter;
   } req_type;

   typedef struct packed {
      logic              pair_valid;
      logic [CODE_W-1:0] first_out;
      logic [CODE_W-1:0] second_out;
      logic              final_pair;
   } rsp_type;

   // digraph handed from the pair former to the square lookup
   typedef struct packed {
      logic              do_xform;
      logic              final_pair;
      logic [CODE_W-1:0] first;
      logic [CODE_W-1:0] second;
   } pair_type;

endpackage

[rtl/core/pfc_csr_regs.sv]
// ----------------------------------------------------------------------------
// pfc_csr_regs
// key square and direction registers behind the apb-style port
// ----------------------------------------------------------------------------
module pfc_csr_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pfc_pkg::ADDR_W-1:0]       paddr,
   input  logic [pfc_pkg::DATA_W-1:0]       pwdata,
   output logic [pfc_pkg::DATA_W-1:0]       prdata,
   output logic                             pready,
   output pfc_pkg::cells_type               cells,
   output logic                             direction
);

   localparam int LOW_W  = pfc_pkg::CELLS_PER_REG * pfc_pkg::CODE_W;
   localparam int HIGH_CELLS = pfc_pkg::CELL_COUNT - 2 * pfc_pkg::CELLS_PER_REG;
   localparam int HIGH_W = HIGH_CELLS * pfc_pkg::CODE_W;

   logic [LOW_W-1:0]  cells_low_ff,  cells_low_in;
   logic [LOW_W-1:0]  cells_mid_ff,  cells_mid_in;
   logic [HIGH_W-1:0] cells_high_ff, cells_high_in;
   logic              direction_ff,  direction_in;
   logic              write_en;
   logic [pfc_pkg::REG_IDX_W-1:0] reg_idx;

   assign pready   = 1'b1;
   assign reg_idx  = paddr[pfc_pkg::ADDR_W-1:3];
   assign write_en = psel & penable & pwrite & pready;

   always_comb begin
      cells_low_in  = cells_low_ff;
      cells_mid_in  = cells_mid_ff;
      cells_high_in = cells_high_ff;
      direction_in  = direction_ff;
      if (write_en) begin
         unique case (reg_idx)
            pfc_pkg::REG_CELLS_LOW:  cells_low_in  = pwdata[LOW_W-1:0];
            pfc_pkg::REG_CELLS_MID:  cells_mid_in  = pwdata[LOW_W-1:0];
            pfc_pkg::REG_CELLS_HIGH: cells_high_in = pwdata[HIGH_W-1:0];
            pfc_pkg::REG_DIRECTION:  direction_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_low_ff  <= '0;
         cells_mid_ff  <= '0;
         cells_high_ff <= '0;
         direction_ff  <= pfc_pkg::DIR_ENCRYPT;
      end else begin
         cells_low_ff  <= cells_low_in;
         cells_mid_ff  <= cells_mid_in;
         cells_high_ff <= cells_high_in;
         direction_ff  <= direction_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         pfc_pkg::REG_CELLS_LOW:  prdata = pfc_pkg::DATA_W'(cells_low_ff);
         pfc_pkg::REG_CELLS_MID:  prdata = pfc_pkg::DATA_W'(cells_mid_ff);
         pfc_pkg::REG_CELLS_HIGH: prdata = pfc_pkg::DATA_W'(cells_high_ff);
         pfc_pkg::REG_DIRECTION:  prdata = pfc_pkg::DATA_W'(direction_ff);
         default:                 prdata = '0;
      endcase
   end

   // unpack into one code per cell, row-major
   always_comb begin
      for (int i = 0; i < pfc_pkg::CELLS_PER_REG; i++) begin
         cells[i] = cells_low_ff[i*pfc_pkg::CODE_W +: pfc_pkg::CODE_W];
         cells[i+pfc_pkg::CELLS_PER_REG] =
            cells_mid_ff[i*pfc_pkg::CODE_W +: pfc_pkg::CODE_W];
      end
      for (int i = 0; i < HIGH_CELLS; i++) begin
         cells[i+2*pfc_pkg::CELLS_PER_REG] =
            cells_high_ff[i*pfc_pkg::CODE_W +: pfc_pkg::CODE_W];
      end
   end

   assign direction = direction_ff;

endmodule

[rtl/core/pfc_pair_former.sv]
// ----------------------------------------------------------------------------
// pfc_pair_former
// folds j into i, inserts fillers before doubled letters, pads at end of
// message and registers each digraph for the square lookup
// ----------------------------------------------------------------------------
module pfc_pair_former (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  pfc_pkg::req_type   req_data,
   output pfc_pkg::pair_type  pair
);

   logic                       held_ff,         held_in;
   logic [pfc_pkg::CODE_W-1:0] held_letter_ff,  held_letter_in;
   logic                       prior_seen_ff,   prior_seen_in;
   logic [pfc_pkg::CODE_W-1:0] prior_letter_ff, prior_letter_in;
   pfc_pkg::pair_type          pair_ff,         pair_in;

   logic [pfc_pkg::CODE_W-1:0] letter;
   logic [pfc_pkg::CODE_W-1:0] filler;
   logic                       doubled;

   assign letter  = (req_data.letter == pfc_pkg::CODE_J) ? pfc_pkg::CODE_I : req_data.letter;
   assign doubled = prior_seen_ff && (letter == prior_letter_ff);
   assign filler  = (prior_letter_ff == pfc_pkg::CODE_X) ? pfc_pkg::CODE_Q : pfc_pkg::CODE_X;

   always_comb begin
      held_in         = held_ff;
      held_letter_in  = held_letter_ff;
      prior_seen_in   = prior_seen_ff;
      prior_letter_in = prior_letter_ff;
      pair_in         = '0;
      if (req_data.cmd == pfc_pkg::CMD_LETTER) begin
         prior_seen_in   = 1'b1;
         prior_letter_in = letter;
         if (doubled) begin
            // filler closes the open pair and the letter is held, or filler and letter form a pair
            pair_in.do_xform = 1'b1;
            if (held_ff) begin
               pair_in.first  = held_letter_ff;
               pair_in.second = filler;
               held_letter_in = letter;
            end else begin
               pair_in.first  = filler;
               pair_in.second = letter;
            end
         end else if (held_ff) begin
            pair_in.do_xform = 1'b1;
            pair_in.first    = held_letter_ff;
            pair_in.second   = letter;
            held_in          = 1'b0;
         end else begin
            held_in        = 1'b1;
            held_letter_in = letter;
         end
      end else begin
         pair_in.final_pair = 1'b1;
         if (held_ff) begin
            pair_in.do_xform = 1'b1;
            if (held_letter_ff == pfc_pkg::CODE_Z) begin
               pair_in.first  = pfc_pkg::CODE_Z;
               pair_in.second = pfc_pkg::CODE_X;
            end else begin
               pair_in.first  = held_letter_ff;
               pair_in.second = pfc_pkg::CODE_Z;
            end
         end else if (prior_seen_ff && (prior_letter_ff == pfc_pkg::CODE_Z)) begin
            pair_in.do_xform = 1'b1;
            pair_in.first    = pfc_pkg::CODE_X;
            pair_in.second   = pfc_pkg::CODE_Z;
         end
         held_in         = 1'b0;
         held_letter_in  = '0;
         prior_seen_in   = 1'b0;
         prior_letter_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff         <= 1'b0;
         held_letter_ff  <= '0;
         prior_seen_ff   <= 1'b0;
         prior_letter_ff <= '0;
      end else if (load) begin
         held_ff         <= held_in;
         held_letter_ff  <= held_letter_in;
         prior_seen_ff   <= prior_seen_in;
         prior_letter_ff <= prior_letter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pair_ff <= pair_in;
      end
   end

   assign pair = pair_ff;

endmodule

[rtl/core/pfc_square_xform.sv]
// ----------------------------------------------------------------------------
// pfc_square_xform
// finds both letters of a digraph in the key square and applies the row,
// column or rectangle rule
// ----------------------------------------------------------------------------
module pfc_square_xform (
   input  pfc_pkg::cells_type          cells,
   input  logic                        direction,
   input  pfc_pkg::pair_type           pair,
   output logic                        found,
   output logic [pfc_pkg::CODE_W-1:0]  first_out,
   output logic [pfc_pkg::CODE_W-1:0]  second_out
);

   localparam logic [pfc_pkg::POS_W-1:0] LAST_POS = pfc_pkg::POS_W'(pfc_pkg::GRID_SIDE - 1);

   logic                         hit1, hit2;
   logic [pfc_pkg::IDX_W-1:0]    idx1, idx2, nidx1, nidx2;
   logic [pfc_pkg::POS_W-1:0]    r1, c1, r2, c2, nr1, nc1, nr2, nc2;

   function automatic logic [pfc_pkg::POS_W-1:0] step(input logic [pfc_pkg::POS_W-1:0] v,
                                                      input logic back);
      if (back == pfc_pkg::DIR_DECRYPT) begin
         return (v == '0) ? LAST_POS : v - 1'b1;
      end
      return (v == LAST_POS) ? '0 : v + 1'b1;
   endfunction

   function automatic logic [pfc_pkg::IDX_W-1:0] cell_at(input logic [pfc_pkg::POS_W-1:0] r,
                                                         input logic [pfc_pkg::POS_W-1:0] c);
      return pfc_pkg::IDX_W'(r) * pfc_pkg::IDX_W'(pfc_pkg::GRID_SIDE) + pfc_pkg::IDX_W'(c);
   endfunction

   // lowest-numbered matching cell wins; codes above z never match
   always_comb begin
      hit1 = 1'b0;
      hit2 = 1'b0;
      idx1 = '0;
      idx2 = '0;
      for (int i = pfc_pkg::CELL_COUNT - 1; i >= 0; i--) begin
         if (cells[i] <= pfc_pkg::CODE_MAX && cells[i] == pair.first) begin
            hit1 = 1'b1;
            idx1 = pfc_pkg::IDX_W'(i);
         end
         if (cells[i] <= pfc_pkg::CODE_MAX && cells[i] == pair.second) begin
            hit2 = 1'b1;
            idx2 = pfc_pkg::IDX_W'(i);
         end
      end
   end

   assign r1 = pfc_pkg::ROW_OF[idx1];
   assign c1 = pfc_pkg::COL_OF[idx1];
   assign r2 = pfc_pkg::ROW_OF[idx2];
   assign c2 = pfc_pkg::COL_OF[idx2];

   always_comb begin
      if (r1 == r2) begin
         nr1 = r1;
         nr2 = r2;
         nc1 = step(c1, direction);
         nc2 = step(c2, direction);
      end else if (c1 == c2) begin
         nc1 = c1;
         nc2 = c2;
         nr1 = step(r1, direction);
         nr2 = step(r2, direction);
      end else begin
         nr1 = r1;
         nc1 = c2;
         nr2 = r2;
         nc2 = c1;
      end
   end

   assign nidx1      = cell_at(nr1, nc1);
   assign nidx2      = cell_at(nr2, nc2);
   assign found      = hit1 & hit2;
   assign first_out  = cells[nidx1];
   assign second_out = cells[nidx2];

endmodule

[rtl/core/playfair_digraph_cipher_top.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top
// streaming playfair digraph cipher over a software-loaded 5x5 key square
// ----------------------------------------------------------------------------
// Takes one request beat per clock while the response side does not stall: a
// letter or an end-of-message beat goes into the pair register on the cycle
// it is taken, the key square lookup runs between that register and the
// result register, and the result register offers the response beat. The
// lookup (25 compares per letter, a small row/column step and a cell select)
// is the logic that sets the clock. Letter beats give a response only when
// they complete a digraph whose letters are both in the square; every end
// beat gives exactly one response with final_pair set, carrying the padded
// pair if there is one. Load the three key square registers (cells row-major,
// five bits each, codes above 25 mean empty) and direction while idle.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_top (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  pfc_pkg::req_type            req_data,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pfc_pkg::rsp_type            rsp_data,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pfc_pkg::ADDR_W-1:0]  paddr,
   input  logic [pfc_pkg::DATA_W-1:0]  pwdata,
   output logic [pfc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   pfc_pkg::cells_type          cells;
   logic                        direction;
   pfc_pkg::pair_type           pair;
   logic                        found;
   logic [pfc_pkg::CODE_W-1:0]  first_out;
   logic [pfc_pkg::CODE_W-1:0]  second_out;

   logic                        pair_valid_ff, pair_valid_in;
   logic                        rsp_valid_ff,  rsp_valid_in;
   pfc_pkg::rsp_type            rsp_data_ff,   rsp_data_in;

   logic                        req_take;
   logic                        out_free;
   logic                        has_result;

   // key square and direction
   pfc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .cells     (cells),
      .direction (direction)
   );

   // result register can take a new beat when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // hold the request side only while the pair register is stuck
   assign req_stall = pair_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // letter stream to digraphs, holds the message state
   pfc_pair_former u_former (
      .clock    (clock),
      .reset    (reset),
      .load     (req_take),
      .req_data (req_data),
      .pair     (pair)
   );

   // key square lookup and substitution
   pfc_square_xform u_xform (
      .cells      (cells),
      .direction  (direction),
      .pair       (pair),
      .found      (found),
      .first_out  (first_out),
      .second_out (second_out)
   );

   // end beats always answer; letter pairs only when both letters are found
   assign has_result = pair.final_pair || (pair.do_xform && found);

   always_comb begin
      pair_valid_in = pair_valid_ff;
      if (req_take) begin
         pair_valid_in = 1'b1;
      end else if (out_free) begin
         pair_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in           = rsp_valid_ff;
      rsp_data_in            = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in           = pair_valid_ff && has_result;
         rsp_data_in.pair_valid = pair.do_xform && found;
         rsp_data_in.first_out  = (pair.do_xform && found) ? first_out  : '0;
         rsp_data_in.second_out = (pair.do_xform && found) ? second_out : '0;
         rsp_data_in.final_pair = pair.final_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pair_valid_ff <= pair_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[dv/playfair_digraph_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// playfair_digraph_checker
// follows the key square writes and request beats, works out every response
// beat of the cipher and compares it field by field with the block's output
// ----------------------------------------------------------------------------
module playfair_digraph_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  pfc_pkg::req_type           req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  pfc_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [pfc_pkg::ADDR_W-1:0] paddr,
   input  logic [pfc_pkg::DATA_W-1:0] pwdata,
   output int                         fail_count,
   output int                         pending
);

   localparam int CODE_W    = pfc_pkg::CODE_W;
   localparam int REG_BITS  = pfc_pkg::CELLS_PER_REG * pfc_pkg::CODE_W;
   localparam int HIGH_BITS = (pfc_pkg::CELL_COUNT - 2 * pfc_pkg::CELLS_PER_REG)
                              * pfc_pkg::CODE_W;
   localparam int ADDR_LSB  = 3;
   localparam int PRINT_CAP = 40;

   logic [pfc_pkg::CELL_COUNT*CODE_W-1:0] key_cells;
   logic                                  key_dir;
   logic                                  half_held;
   logic [CODE_W-1:0]                     held_code;
   logic                                  prior_seen;
   logic [CODE_W-1:0]                     prior_code;
   pfc_pkg::rsp_type                      digraphs_due[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP)
         $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic [CODE_W-1:0] cell_at(input int idx);
      return key_cells[idx*CODE_W +: CODE_W];
   endfunction

   // lowest matching cell wins, codes above 25 are empty cells
   function automatic bit locate(input logic [CODE_W-1:0] code, output int row,
                                 output int col);
      row = 0;
      col = 0;
      for (int i = 0; i < pfc_pkg::CELL_COUNT; i++) begin
         if (cell_at(i) <= pfc_pkg::CODE_MAX && cell_at(i) == code) begin
            row = i / pfc_pkg::GRID_SIDE;
            col = i % pfc_pkg::GRID_SIDE;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic int shift_pos(input int pos);
      if (key_dir == pfc_pkg::DIR_DECRYPT)
         return (pos == 0) ? pfc_pkg::GRID_SIDE - 1 : pos - 1;
      return (pos == pfc_pkg::GRID_SIDE - 1) ? 0 : pos + 1;
   endfunction

   function automatic bit cipher_pair(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
                                      output logic [CODE_W-1:0] oa,
                                      output logic [CODE_W-1:0] ob);
      int r1, c1, r2, c2, tmp;
      oa = '0;
      ob = '0;
      if (!locate(a, r1, c1) || !locate(b, r2, c2))
         return 1'b0;
      if (r1 == r2) begin
         c1 = shift_pos(c1);
         c2 = shift_pos(c2);
      end else if (c1 == c2) begin
         r1 = shift_pos(r1);
         r2 = shift_pos(r2);
      end else begin
         tmp = c1;
         c1  = c2;
         c2  = tmp;
      end
      oa = cell_at(r1 * pfc_pkg::GRID_SIDE + c1);
      ob = cell_at(r2 * pfc_pkg::GRID_SIDE + c2);
      return 1'b1;
   endfunction

   task automatic add_to_pair(input logic [CODE_W-1:0] code, inout bit got,
                              inout pfc_pkg::rsp_type due);
      logic [CODE_W-1:0] fa, fb;
      if (half_held) begin
         half_held = 1'b0;
         if (cipher_pair(held_code, code, fa, fb)) begin
            got            = 1'b1;
            due.first_out  = fa;
            due.second_out = fb;
         end
      end else begin
         half_held = 1'b1;
         held_code = code;
      end
   endtask

   task automatic predict_beat(input pfc_pkg::req_type beat);
      pfc_pkg::rsp_type  due;
      logic [CODE_W-1:0] code, fa, fb;
      bit                got;
      due = '0;
      got = 1'b0;
      fa  = '0;
      fb  = '0;
      if (beat.cmd == pfc_pkg::CMD_LETTER) begin
         code = (beat.letter == pfc_pkg::CODE_J) ? pfc_pkg::CODE_I : beat.letter;
         // filler ahead of a repeated letter
         if (prior_seen && code == prior_code) begin
            if (prior_code == pfc_pkg::CODE_X)
               add_to_pair(pfc_pkg::CODE_Q, got, due);
            else
               add_to_pair(pfc_pkg::CODE_X, got, due);
         end
         add_to_pair(code, got, due);
         prior_seen = 1'b1;
         prior_code = code;
         if (got) begin
            due.pair_valid = 1'b1;
            digraphs_due   = {digraphs_due, due};
         end
      end else begin
         // end of message padding
         if (half_held) begin
            if (held_code == pfc_pkg::CODE_Z)
               got = cipher_pair(pfc_pkg::CODE_Z, pfc_pkg::CODE_X, fa, fb);
            else
               got = cipher_pair(held_code, pfc_pkg::CODE_Z, fa, fb);
         end else if (prior_seen && prior_code == pfc_pkg::CODE_Z) begin
            got = cipher_pair(pfc_pkg::CODE_X, pfc_pkg::CODE_Z, fa, fb);
         end
         half_held  = 1'b0;
         held_code  = '0;
         prior_seen = 1'b0;
         prior_code = '0;
         due.pair_valid = got;
         due.final_pair = 1'b1;
         if (got) begin
            due.first_out  = fa;
            due.second_out = fb;
         end
         digraphs_due = {digraphs_due, due};
      end
   endtask

   task automatic check_beat(input pfc_pkg::rsp_type seen);
      pfc_pkg::rsp_type due;
      if (digraphs_due.size() == 0) begin
         report_mismatch($sformatf("response beat %h with nothing expected", seen));
      end else begin
         due = digraphs_due.pop_front();
         if (seen.pair_valid !== due.pair_valid)
            report_mismatch($sformatf("pair_valid %b, expected %b",
                                      seen.pair_valid, due.pair_valid));
         if (seen.first_out !== due.first_out)
            report_mismatch($sformatf("first_out %0d, expected %0d",
                                      seen.first_out, due.first_out));
         if (seen.second_out !== due.second_out)
            report_mismatch($sformatf("second_out %0d, expected %0d",
                                      seen.second_out, due.second_out));
         if (seen.final_pair !== due.final_pair)
            report_mismatch($sformatf("final_pair %b, expected %b",
                                      seen.final_pair, due.final_pair));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         key_cells  = '0;
         key_dir    = pfc_pkg::DIR_ENCRYPT;
         half_held  = 1'b0;
         held_code  = '0;
         prior_seen = 1'b0;
         prior_code = '0;
         digraphs_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[pfc_pkg::ADDR_W-1:ADDR_LSB])
               pfc_pkg::REG_CELLS_LOW:
                  key_cells[0 +: REG_BITS] = pwdata[REG_BITS-1:0];
               pfc_pkg::REG_CELLS_MID:
                  key_cells[REG_BITS +: REG_BITS] = pwdata[REG_BITS-1:0];
               pfc_pkg::REG_CELLS_HIGH:
                  key_cells[2*REG_BITS +: HIGH_BITS] = pwdata[HIGH_BITS-1:0];
               pfc_pkg::REG_DIRECTION:
                  key_dir = pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_beat(req_data);
         if (rsp_valid && !rsp_stall)
            check_beat(rsp_data);
      end
      pending = digraphs_due.size();
   end

endmodule

[dv/tb_playfair_digraph_cipher_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_playfair_digraph_cipher_top
// drives letter and end-of-message beats through the cipher under a series
// of key squares and directions, with random idling on both channels, and
// leaves the checking to the checker beside the block
// ----------------------------------------------------------------------------
module tb_playfair_digraph_cipher_top;

   localparam int CODE_W        = pfc_pkg::CODE_W;
   localparam int CELL_COUNT    = pfc_pkg::CELL_COUNT;
   localparam int QUIET_LIMIT   = 4000;  // cycles with no beat before giving up
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;   // receiver hold-off that backs the block up
   localparam int PHASE_BEATS   = 100;
   localparam int SHORT_BEATS   = 40;
   localparam int REG_BITS      = pfc_pkg::CELLS_PER_REG * CODE_W;
   localparam int HIGH_BITS     = (CELL_COUNT - 2 * pfc_pkg::CELLS_PER_REG) * CODE_W;
   localparam int ADDR_LSB      = 3;

   // letter codes used by the directed beats
   localparam logic [CODE_W-1:0] LTR_A      = 5'd0;
   localparam logic [CODE_W-1:0] LTR_B      = 5'd1;
   localparam logic [CODE_W-1:0] LTR_E      = 5'd4;
   localparam logic [CODE_W-1:0] LTR_F      = 5'd5;
   localparam logic [CODE_W-1:0] LTR_I      = 5'd8;
   localparam logic [CODE_W-1:0] LTR_K      = 5'd10;
   localparam logic [CODE_W-1:0] LTR_M      = 5'd12;
   localparam logic [CODE_W-1:0] LTR_V      = 5'd21;
   localparam logic [CODE_W-1:0] LTR_Y      = 5'd24;
   localparam logic [CODE_W-1:0] CODE_EMPTY = 5'd31;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   pfc_pkg::req_type           req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   pfc_pkg::rsp_type           rsp_data;
   logic                       psel      = 1'b0;
   logic                       penable   = 1'b0;
   logic                       pwrite    = 1'b0;
   logic [pfc_pkg::ADDR_W-1:0] paddr     = '0;
   logic [pfc_pkg::DATA_W-1:0] pwdata    = '0;
   logic [pfc_pkg::DATA_W-1:0] prdata;
   logic                       pready;

   int  fail_count;
   int  pending;
   bit  idle_on      = 1'b1;   // random idling on both channels
   bit  hold_request = 1'b0;   // asks the receiver for one long hold-off
   logic [CELL_COUNT*CODE_W-1:0] cur_cells = '0;
   logic [CODE_W-1:0]            last_letter = '0;
   int  req_beats      = 0;
   int  rsp_beats      = 0;
   int  squares_loaded = 0;
   int  quiet          = 0;

   always #5 clock = ~clock;

   playfair_digraph_cipher_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   playfair_digraph_checker cipher_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // watchdog: counts cycles in which no beat and no register write happen,
   // and also tallies the beats for the summary
   initial begin : watchdog
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (req_valid && !req_stall)
            req_beats++;
         if (rsp_valid && !rsp_stall)
            rsp_beats++;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable && pwrite && pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: %0d cycles without any beat", QUIET_LIMIT);
      $display("** playfair_digraph_cipher_top: FAILED **");
      $finish;
   end

   // response side: random stall bursts, or one long hold when asked;
   // the hold is counted here so the sender keeps offering beats meanwhile
   initial begin : rsp_side
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // one register write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [pfc_pkg::REG_IDX_W-1:0] idx,
                            input logic [pfc_pkg::DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, {ADDR_LSB{1'b0}}};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // waits for the block to drain, then loads a square and a direction
   task automatic load_square(input logic [CELL_COUNT*CODE_W-1:0] cells, input logic dir);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      // letter beats that give no response may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(pfc_pkg::REG_CELLS_LOW, pfc_pkg::DATA_W'(cells[0 +: REG_BITS]));
      csr_write(pfc_pkg::REG_CELLS_MID, pfc_pkg::DATA_W'(cells[REG_BITS +: REG_BITS]));
      csr_write(pfc_pkg::REG_CELLS_HIGH, pfc_pkg::DATA_W'(cells[2*REG_BITS +: HIGH_BITS]));
      csr_write(pfc_pkg::REG_DIRECTION, pfc_pkg::DATA_W'(dir));
      cur_cells = cells;
      squares_loaded++;
   endtask

   // one request beat, with an occasional idle burst ahead of it;
   // valid stays high from beat to beat unless a gap is taken
   task automatic send_beat(input logic cmd, input logic [CODE_W-1:0] code);
      pfc_pkg::req_type beat;
      beat.cmd    = cmd;
      beat.letter = code;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (cmd == pfc_pkg::CMD_LETTER)
         last_letter = code;
   endtask

   // mostly letters from the current square, with a share of repeats (filler),
   // X, Z, J and codes that no square cell can hold
   function automatic logic [CODE_W-1:0] pick_letter();
      int                roll;
      int                idx;
      logic [CODE_W-1:0] code;
      roll = $urandom_range(0, 99);
      if (roll < 12)
         return last_letter;
      if (roll < 17)
         return pfc_pkg::CODE_X;
      if (roll < 22)
         return pfc_pkg::CODE_Z;
      if (roll < 26)
         return pfc_pkg::CODE_J;
      if (roll < 28)
         return CODE_W'($urandom_range(pfc_pkg::CODE_MAX + 1, CODE_EMPTY));
      idx  = $urandom_range(0, CELL_COUNT - 1);
      code = cur_cells[idx*CODE_W +: CODE_W];
      return (code > pfc_pkg::CODE_MAX) ? CODE_W'($urandom_range(0, pfc_pkg::CODE_MAX))
                                        : code;
   endfunction

   // a message is some letters and an end beat; one in ten is raw noise
   task automatic send_message(inout int budget);
      int len;
      bit noise;
      noise = ($urandom_range(0, 9) == 0);
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      for (int i = 0; i < len; i++) begin
         if (noise)
            send_beat(pfc_pkg::CMD_LETTER, CODE_W'($urandom_range(0, CODE_EMPTY)));
         else
            send_beat(pfc_pkg::CMD_LETTER, pick_letter());
      end
      // the letter field of an end beat is don't-care, so randomize it
      send_beat(pfc_pkg::CMD_END, CODE_W'($urandom_range(0, CODE_EMPTY)));
      budget -= len + 1;
   endtask

   task automatic run_phase(input logic [CELL_COUNT*CODE_W-1:0] cells, input logic dir,
                            input int beats, input bit squeeze);
      int left;
      load_square(cells, dir);
      left = beats;
      while (left > 0) begin
         // once the phase is under way, hold off the receiver for a long stretch
         if (squeeze && left < beats - 20) begin
            hold_request = 1'b1;
            squeeze      = 1'b0;
         end
         send_message(left);
      end
   endtask

   // the 25 letters without J, in order or shuffled
   function automatic logic [CELL_COUNT*CODE_W-1:0] letter_square(input bit shuffle);
      logic [CODE_W-1:0]            pool [CELL_COUNT];
      logic [CODE_W-1:0]            swap;
      logic [CELL_COUNT*CODE_W-1:0] cells;
      int                           n, k;
      n = 0;
      for (int c = 0; c <= pfc_pkg::CODE_MAX; c++) begin
         if (c != pfc_pkg::CODE_J) begin
            pool[n] = CODE_W'(c);
            n++;
         end
      end
      if (shuffle) begin
         for (int i = CELL_COUNT - 1; i > 0; i--) begin
            k       = $urandom_range(0, i);
            swap    = pool[i];
            pool[i] = pool[k];
            pool[k] = swap;
         end
      end
      for (int i = 0; i < CELL_COUNT; i++)
         cells[i*CODE_W +: CODE_W] = pool[i];
      return cells;
   endfunction

   // random cells: empty ones and repeated letters
   function automatic logic [CELL_COUNT*CODE_W-1:0] patchy_square();
      logic [CELL_COUNT*CODE_W-1:0] cells;
      for (int i = 0; i < CELL_COUNT; i++) begin
         if ($urandom_range(0, 4) == 0)
            cells[i*CODE_W +: CODE_W] =
               CODE_W'($urandom_range(pfc_pkg::CODE_MAX + 1, CODE_EMPTY));
         else
            cells[i*CODE_W +: CODE_W] = CODE_W'($urandom_range(0, pfc_pkg::CODE_MAX));
      end
      return cells;
   endfunction

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed beats over the alphabetic square, encrypting
      load_square(letter_square(1'b0), pfc_pkg::DIR_ENCRYPT);
      // end of an empty message
      send_beat(pfc_pkg::CMD_END, LTR_A);
      // row, row with wrap, filler for the doubled A, column with wrap, row
      send_beat(pfc_pkg::CMD_LETTER, LTR_A); send_beat(pfc_pkg::CMD_LETTER, LTR_B);
      send_beat(pfc_pkg::CMD_LETTER, LTR_E); send_beat(pfc_pkg::CMD_LETTER, LTR_A);
      send_beat(pfc_pkg::CMD_LETTER, LTR_A); send_beat(pfc_pkg::CMD_LETTER, LTR_F);
      send_beat(pfc_pkg::CMD_LETTER, LTR_V); send_beat(pfc_pkg::CMD_LETTER, LTR_A);
      send_beat(pfc_pkg::CMD_LETTER, LTR_B); send_beat(pfc_pkg::CMD_LETTER, LTR_M);
      // J folds to I and repeats, so X is inserted; a doubled X takes Q
      send_beat(pfc_pkg::CMD_LETTER, pfc_pkg::CODE_J);
      send_beat(pfc_pkg::CMD_LETTER, LTR_I);
      send_beat(pfc_pkg::CMD_LETTER, pfc_pkg::CODE_X);
      send_beat(pfc_pkg::CMD_LETTER, pfc_pkg::CODE_X);
      // Z pairs with the held X, so the end beat pads with XZ
      send_beat(pfc_pkg::CMD_LETTER, pfc_pkg::CODE_Z);
      send_beat(pfc_pkg::CMD_END, CODE_EMPTY);
      // odd length ending elsewhere pads with Z
      send_beat(pfc_pkg::CMD_LETTER, LTR_K); send_beat(pfc_pkg::CMD_END, LTR_A);
      // even length ending in Z pads with XZ
      send_beat(pfc_pkg::CMD_LETTER, LTR_Y);
      send_beat(pfc_pkg::CMD_LETTER, pfc_pkg::CODE_Z);
      send_beat(pfc_pkg::CMD_END, pfc_pkg::CODE_Z);
      // a code no cell holds drops the pair, and there is nothing to pad
      send_beat(pfc_pkg::CMD_LETTER, CODE_EMPTY); send_beat(pfc_pkg::CMD_LETTER, LTR_A);
      send_beat(pfc_pkg::CMD_END, LTR_A);

      // random messages over a series of squares and directions
      run_phase(letter_square(1'b1), pfc_pkg::DIR_ENCRYPT, PHASE_BEATS, 1'b0);
      run_phase(letter_square(1'b1), pfc_pkg::DIR_DECRYPT, PHASE_BEATS, 1'b0);
      run_phase(letter_square(1'b0), pfc_pkg::DIR_DECRYPT, PHASE_BEATS, 1'b0);
      run_phase(patchy_square(), pfc_pkg::DIR_ENCRYPT, PHASE_BEATS, 1'b0);
      // all-ones registers: every cell empty, every pair dropped
      run_phase('1, pfc_pkg::DIR_ENCRYPT, SHORT_BEATS, 1'b0);
      // all-zero registers: every cell holds A, only A is ever found
      run_phase('0, pfc_pkg::DIR_DECRYPT, SHORT_BEATS, 1'b0);
      // long receiver hold while the sender keeps going
      run_phase(letter_square(1'b1), pfc_pkg::DIR_DECRYPT, PHASE_BEATS, 1'b1);
      // last stretch at full rate, no idling on either side
      idle_on = 1'b0;
      run_phase(patchy_square(), pfc_pkg::DIR_DECRYPT, PHASE_BEATS, 1'b0);
      run_phase(letter_square(1'b1), pfc_pkg::DIR_ENCRYPT, PHASE_BEATS, 1'b0);

      // drain: every expected beat in, then a settling wait for stragglers
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d request beats, %0d response beats, %0d key square loads",
               req_beats, rsp_beats, squares_loaded);
      $display("run: both directions, empty and repeated cells, fillers, padding, long hold");
      if (fail_count == 0 && pending == 0)
         $display("** playfair_digraph_cipher_top: PASSED **");
      else
         $display("** playfair_digraph_cipher_top: FAILED **");
      $finish;
   end

endmodule
